// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/mvh_pkg.sv =====
// ----------------------------------------------------------------------------
// Magnetometer vane heading package
// Shared constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package mvh_pkg;

    localparam int AngleTableLen = 24;
    localparam int AngW          = 34;
    localparam int DatW          = 40;
    localparam int FullTenths    = 3600;

    localparam logic [2:0] ModeYxPos = 3'd0;
    localparam logic [2:0] ModeYxNeg = 3'd1;
    localparam logic [2:0] ModeYzPos = 3'd2;
    localparam logic [2:0] ModeYzNeg = 3'd3;
    localparam logic [2:0] ModeZxPos = 3'd4;
    localparam logic [2:0] ModeZxNeg = 3'd5;

    localparam logic [2:0] RegAxisMode   = 3'd0;
    localparam logic [2:0] RegOffsetX    = 3'd1;
    localparam logic [2:0] RegOffsetY    = 3'd2;
    localparam logic [2:0] RegOffsetZ    = 3'd3;
    localparam logic [2:0] RegNorth      = 3'd4;
    localparam logic [2:0] RegAxisScale  = 3'd5;
    localparam logic [2:0] RegCalEnable  = 3'd6;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic iterate;
        logic finish;
        logic sector;
        logic [4:0] step;
    } mvh_cmd_t;

    // atan(2^-i) in tenths of a degree, 16 fraction bits.
    function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] i);
        logic signed [AngW-1:0] r;
        begin
            case (i)
                5'd0:  r = 34'sd29491200;
                5'd1:  r = 34'sd17409672;
                5'd2:  r = 34'sd9198793;
                5'd3:  r = 34'sd4669451;
                5'd4:  r = 34'sd2343786;
                5'd5:  r = 34'sd1173036;
                5'd6:  r = 34'sd586661;
                5'd7:  r = 34'sd293348;
                5'd8:  r = 34'sd146676;
                5'd9:  r = 34'sd73339;
                5'd10: r = 34'sd36669;
                5'd11: r = 34'sd18335;
                5'd12: r = 34'sd9167;
                5'd13: r = 34'sd4584;
                5'd14: r = 34'sd2292;
                5'd15: r = 34'sd1146;
                5'd16: r = 34'sd573;
                5'd17: r = 34'sd286;
                5'd18: r = 34'sd143;
                5'd19: r = 34'sd72;
                5'd20: r = 34'sd36;
                5'd21: r = 34'sd18;
                5'd22: r = 34'sd9;
                5'd23: r = 34'sd4;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/mvh_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload with valid and ready between a source and a sink.
// ----------------------------------------------------------------------------
interface mvh_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/mvh_ctrl.sv =====
// ----------------------------------------------------------------------------
// Heading controller
// Sequences load, CORDIC iterations, finishing steps and result hand-off.
// ----------------------------------------------------------------------------
module mvh_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output mvh_pkg::mvh_cmd_t cmd
);
    localparam logic [2:0] StIdle   = 3'd0;
    localparam logic [2:0] StIter   = 3'd1;
    localparam logic [2:0] StFinish = 3'd2;
    localparam logic [2:0] StSector = 3'd3;
    localparam logic [2:0] StOut    = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;

    assign in_ready  = (state_reg == StIdle);
    assign out_valid = (state_reg == StOut);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            StIdle:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = StIter;
                end
            end
            StIter:
            begin
                cmd.iterate = 1'b1;
                step_next   = step_reg + 5'd1;
                if (step_reg == 5'(CORDIC_STEPS - 1))
                    state_next = StFinish;
            end
            StFinish:
            begin
                cmd.finish = 1'b1;
                state_next = StSector;
            end
            StSector:
            begin
                cmd.sector = 1'b1;
                state_next = StOut;
            end
            StOut:
            begin
                if (out_ready)
                    state_next = StIdle;
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end
endmodule

// ===== rtl/mvh_datapath.sv =====
// ----------------------------------------------------------------------------
// Heading datapath
// Offset removal, axis selection, scaling, iterative CORDIC, heading wrap,
// sector and calibration extremes.
// ----------------------------------------------------------------------------
module mvh_datapath #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mvh_pkg::mvh_cmd_t        cmd,
    input  logic signed [15:0]       mag_x,
    input  logic signed [15:0]       mag_y,
    input  logic signed [15:0]       mag_z,
    input  logic [2:0]               axis_mode,
    input  logic signed [15:0]       offset_x,
    input  logic signed [15:0]       offset_y,
    input  logic signed [15:0]       offset_z,
    input  logic [11:0]              north_offset,
    input  logic signed [15:0]       axis_scale,
    input  logic                     cal_enable,
    output logic [11:0]              heading_tenths,
    output logic [2:0]               sector,
    output logic signed [15:0]       center_x,
    output logic signed [15:0]       center_y,
    output logic signed [15:0]       center_z
);
    localparam int DW = mvh_pkg::DatW;
    localparam int AW = mvh_pkg::AngW;

    logic signed [DW-1:0] x_reg, y_reg;
    logic signed [AW-1:0] z_reg;
    logic [11:0] head_reg;
    logic [2:0]  sect_reg;
    logic signed [15:0] max_x_reg, min_x_reg, max_y_reg, min_y_reg;
    logic signed [15:0] max_z_reg, min_z_reg;

    logic signed [15:0] sx, sy, sz;
    logic signed [16:0] dx, dy, dz, num_d, den_d;
    logic signed [33:0] num_p;
    logic signed [DW-1:0] xn, yn, xs, ys;
    logic signed [AW-1:0] zn;
    logic signed [AW-1:0] tenths;
    logic signed [14:0] total;
    logic [11:0] wrapped;
    logic [12:0] sec_sum;

    assign sx = 16'(signed'(mag_x[SAMPLE_BITS-1:0]));
    assign sy = 16'(signed'(mag_y[SAMPLE_BITS-1:0]));
    assign sz = 16'(signed'(mag_z[SAMPLE_BITS-1:0]));
    assign dx = 17'(sx) - 17'(offset_x);
    assign dy = 17'(sy) - 17'(offset_y);
    assign dz = 17'(sz) - 17'(offset_z);

    always_comb
    begin
        unique case (axis_mode)
            mvh_pkg::ModeYxNeg: begin num_d = -dy; den_d = dx; end
            mvh_pkg::ModeYzPos: begin num_d = dy;  den_d = dz; end
            mvh_pkg::ModeYzNeg: begin num_d = -dy; den_d = dz; end
            mvh_pkg::ModeZxPos: begin num_d = dz;  den_d = dx; end
            mvh_pkg::ModeZxNeg: begin num_d = -dz; den_d = dx; end
            default:            begin num_d = dy;  den_d = dx; end
        endcase
    end
    assign num_p = 34'(num_d) * 34'(axis_scale);

    // Shifts are arithmetic, which rounds toward minus infinity.
    assign xs = x_reg >>> cmd.step;
    assign ys = y_reg >>> cmd.step;

    // Final rounding to tenths and wrap into 0..3599 (the sum is below 3*3600).
    assign tenths = (z_reg + AW'(32768)) >>> 16;
    assign total  = 15'(tenths) + 15'(2 * mvh_pkg::FullTenths) - 15'(north_offset);

    always_comb
    begin
        if (total >= 15'(2 * mvh_pkg::FullTenths))
            wrapped = 12'(total - 15'(2 * mvh_pkg::FullTenths));
        else if (total >= 15'(mvh_pkg::FullTenths))
            wrapped = 12'(total - 15'(mvh_pkg::FullTenths));
        else
            wrapped = 12'(total);
    end
    assign sec_sum = 13'(head_reg) + 13'd225;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            // The quadrant pre-rotation keeps x non-negative for the iterations.
            if (den_d == 17'sd0 && num_d == 17'sd0)
            begin
                x_reg <= '0; y_reg <= '0; z_reg <= '0;
            end
            else if (den_d < 0 && num_p >= 0)
            begin
                x_reg <= DW'(num_p);
                y_reg <= -(DW'(den_d) <<< 8);
                z_reg <= AW'(58982400);
            end
            else if (den_d < 0)
            begin
                x_reg <= -DW'(num_p);
                y_reg <= DW'(den_d) <<< 8;
                z_reg <= -AW'(58982400);
            end
            else
            begin
                x_reg <= DW'(den_d) <<< 8;
                y_reg <= DW'(num_p);
                z_reg <= '0;
            end
        end
        else if (cmd.iterate)
        begin
            if (x_reg != 0 || y_reg != 0)
            begin
                x_reg <= xn;
                y_reg <= yn;
                z_reg <= zn;
            end
        end
        if (cmd.finish)
            head_reg <= wrapped;
        if (cmd.sector)
        begin
            if (sec_sum >= 13'd3600)      sect_reg <= 3'd0;
            else if (sec_sum >= 13'd3150) sect_reg <= 3'd7;
            else if (sec_sum >= 13'd2700) sect_reg <= 3'd6;
            else if (sec_sum >= 13'd2250) sect_reg <= 3'd5;
            else if (sec_sum >= 13'd1800) sect_reg <= 3'd4;
            else if (sec_sum >= 13'd1350) sect_reg <= 3'd3;
            else if (sec_sum >= 13'd900)  sect_reg <= 3'd2;
            else if (sec_sum >= 13'd450)  sect_reg <= 3'd1;
            else                          sect_reg <= 3'd0;
        end
    end

    always_comb
    begin
        if (y_reg > 0)
        begin
            xn = x_reg + ys;
            yn = y_reg - xs;
            zn = z_reg + mvh_pkg::atan_entry(cmd.step);
        end
        else
        begin
            xn = x_reg - ys;
            yn = y_reg + xs;
            zn = z_reg - mvh_pkg::atan_entry(cmd.step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= -16'sd32768; min_x_reg <= 16'sd32767;
            max_y_reg <= -16'sd32768; min_y_reg <= 16'sd32767;
            max_z_reg <= -16'sd32768; min_z_reg <= 16'sd32767;
        end
        else if (cmd.load && cal_enable)
        begin
            if (sx > max_x_reg) max_x_reg <= sx;
            if (sx < min_x_reg) min_x_reg <= sx;
            if (sy > max_y_reg) max_y_reg <= sy;
            if (sy < min_y_reg) min_y_reg <= sy;
            if (sz > max_z_reg) max_z_reg <= sz;
            if (sz < min_z_reg) min_z_reg <= sz;
        end
    end

    function automatic logic signed [15:0] mid(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
        logic signed [16:0] s;
        begin
            s = 17'(a) + 17'(b);
            if (s < 0)
                s = s + 17'sd1;
            return 16'(s >>> 1);
        end
    endfunction

    assign heading_tenths = head_reg;
    assign sector         = sect_reg;
    assign center_x       = mid(max_x_reg, min_x_reg);
    assign center_y       = mid(max_y_reg, min_y_reg);
    assign center_z       = mid(max_z_reg, min_z_reg);
endmodule

// ===== rtl/magnetometer_vane_heading_top.sv =====
// Sequence: a load step, the CORDIC iterations on the shared shift-add
// unit, the finish and sector steps, then the result waits for a transfer.
// A new sample is accepted only in idle, after the previous result is taken.
// Reset: asynchronous active-low; control and configuration registers return
// to their reset values, calibration extremes to their empty values.
// ----------------------------------------------------------------------------
// Magnetometer vane heading top level
// Hard-iron corrected compass heading with sector and calibration centers.
// ----------------------------------------------------------------------------
module magnetometer_vane_heading_top #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    mvh_stream_if.sink   in_ch,
    mvh_stream_if.source out_ch
);
    mvh_pkg::mvh_cmd_t cmd;
    logic [2:0]  axis_mode_reg;
    logic signed [15:0] offset_x_reg, offset_y_reg, offset_z_reg, axis_scale_reg;
    logic [11:0] north_reg;
    logic        cal_reg;
    logic [11:0] heading_tenths;
    logic [2:0]  sector;
    logic signed [15:0] center_x, center_y, center_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_mode_reg  <= '0;
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
            offset_z_reg   <= '0;
            north_reg      <= '0;
            axis_scale_reg <= 16'sd256;
            cal_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mvh_pkg::RegAxisMode:  axis_mode_reg  <= cfg_data[2:0];
                mvh_pkg::RegOffsetX:   offset_x_reg   <= cfg_data;
                mvh_pkg::RegOffsetY:   offset_y_reg   <= cfg_data;
                mvh_pkg::RegOffsetZ:   offset_z_reg   <= cfg_data;
                mvh_pkg::RegNorth:     north_reg      <= cfg_data[11:0];
                mvh_pkg::RegAxisScale: axis_scale_reg <= cfg_data;
                mvh_pkg::RegCalEnable: cal_reg        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    mvh_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd)
    );

    mvh_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .mag_x(in_ch.payload.mag_x), .mag_y(in_ch.payload.mag_y),
        .mag_z(in_ch.payload.mag_z),
        .axis_mode(axis_mode_reg), .offset_x(offset_x_reg),
        .offset_y(offset_y_reg), .offset_z(offset_z_reg),
        .north_offset(north_reg), .axis_scale(axis_scale_reg),
        .cal_enable(cal_reg),
        .heading_tenths(heading_tenths), .sector(sector),
        .center_x(center_x), .center_y(center_y), .center_z(center_z)
    );

    assign out_ch.payload.heading_tenths = heading_tenths;
    assign out_ch.payload.sector         = sector;
    assign out_ch.payload.center_x       = center_x;
    assign out_ch.payload.center_y       = center_y;
    assign out_ch.payload.center_z       = center_z;
endmodule

// ===== rtl/mvh_checker.sv =====
// ----------------------------------------------------------------------------
// Heading port checker
// Watches the top-level ports for ordering and range of results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mvh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] heading_tenths,
    input logic [2:0]  sector
);
    `ASSERT_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input taken during result")
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid, "busy after transfer")
    `ASSERT_IMPLY(a_heading_range, clk, rst_n, out_valid, heading_tenths < 12'd3600, "heading range")
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(sector), "result dropped")
endmodule

bind magnetometer_vane_heading_top mvh_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .heading_tenths(out_ch.payload.heading_tenths),
    .sector(out_ch.payload.sector)
);

// ===== tb/mvh_tb_types_pkg.sv =====
// ----------------------------------------------------------------------------
// Magnetometer vane heading testbench types
// Payload layouts of the sample and result channels, shared by the
// stimulus top and the checker.
// ----------------------------------------------------------------------------
package mvh_tb_types_pkg;

    typedef struct packed {
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
    } mag_sample_t;

    typedef struct packed {
        logic [11:0]        heading_tenths;
        logic [2:0]         sector;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_z;
    } heading_result_t;

endpackage

// ===== tb/mvh_heading_checker.sv =====
// ----------------------------------------------------------------------------
// Magnetometer vane heading checker
// Watches register writes and both channels, computes the expected heading,
// sector and calibration centers for every sample transfer, and compares each
// result transfer against the oldest expected result.
// ----------------------------------------------------------------------------
module mvh_heading_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    mvh_stream_if       sample_mon,
    mvh_stream_if       result_mon,
    output int          fail_count,
    output int          pending
);

    localparam longint Deg90Fix = 58982400;
    localparam longint ArcTable [24] = '{
        29491200, 17409672, 9198793, 4669451, 2343786, 1173036, 586661, 293348,
        146676, 73339, 36669, 18335, 9167, 4584, 2292, 1146,
        573, 286, 143, 72, 36, 18, 9, 4
    };

    logic [2:0]         mode_q;
    logic signed [15:0] off_x, off_y, off_z;
    logic [11:0]        north_q;
    logic signed [15:0] scale_q;
    logic               cal_on;
    int                 hi_x, lo_x, hi_y, lo_y, hi_z, lo_z;

    mvh_tb_types_pkg::heading_result_t expected_headings[$];

    function automatic longint vector_angle(input longint num, input longint den);
        longint x, y, z, t, xs, ys;
        x = den;
        y = num;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = Deg90Fix;
            end
            else
            begin
                x = -y;
                y = t;
                z = -Deg90Fix;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys;
                y -= xs;
                z += ArcTable[i];
            end
            else
            begin
                x -= ys;
                y += xs;
                z -= ArcTable[i];
            end
        end
        return z;
    endfunction

    // Updates the tracked extremes when calibration is on and returns the result for one sample.
    function automatic mvh_tb_types_pkg::heading_result_t heading_of(
        input mvh_tb_types_pkg::mag_sample_t s);
        mvh_tb_types_pkg::heading_result_t r;
        longint dx, dy, dz, num, den, tenths, total;
        int sx, sy, sz;
        sx = s.mag_x;
        sy = s.mag_y;
        sz = s.mag_z;
        dx = sx - int'(off_x);
        dy = sy - int'(off_y);
        dz = sz - int'(off_z);
        if (cal_on)
        begin
            if (sx > hi_x) hi_x = sx;
            if (sx < lo_x) lo_x = sx;
            if (sy > hi_y) hi_y = sy;
            if (sy < lo_y) lo_y = sy;
            if (sz > hi_z) hi_z = sz;
            if (sz < lo_z) lo_z = sz;
        end
        case (mode_q)
            mvh_pkg::ModeYxNeg: begin num = -dy; den = dx; end
            mvh_pkg::ModeYzPos: begin num = dy;  den = dz; end
            mvh_pkg::ModeYzNeg: begin num = -dy; den = dz; end
            mvh_pkg::ModeZxPos: begin num = dz;  den = dx; end
            mvh_pkg::ModeZxNeg: begin num = -dz; den = dx; end
            default:            begin num = dy;  den = dx; end
        endcase
        num = num * longint'(scale_q);
        den = den * 256;
        tenths = (vector_angle(num, den) + 32768) >>> 16;
        total = (tenths + 2 * mvh_pkg::FullTenths - longint'(north_q)) % mvh_pkg::FullTenths;
        if (total < 0)
            total += mvh_pkg::FullTenths;
        r.heading_tenths = total[11:0];
        r.sector = 3'((total + 225) / 450);
        r.center_x = 16'((hi_x + lo_x) / 2);
        r.center_y = 16'((hi_y + lo_y) / 2);
        r.center_z = 16'((hi_z + lo_z) / 2);
        return r;
    endfunction

    assign pending = expected_headings.size();

    always @(posedge clk or negedge rst_n)
    begin
        mvh_tb_types_pkg::heading_result_t want, got;
        if (!rst_n)
        begin
            mode_q  <= mvh_pkg::ModeYxPos;
            off_x   <= '0;
            off_y   <= '0;
            off_z   <= '0;
            north_q <= '0;
            scale_q <= 16'sd256;
            cal_on  <= 1'b0;
            hi_x = -32768; lo_x = 32767;
            hi_y = -32768; lo_y = 32767;
            hi_z = -32768; lo_z = 32767;
            expected_headings.delete();
            fail_count <= 0;
        end
        else
        begin
            if (sample_mon.valid && sample_mon.ready)
                expected_headings.push_back(heading_of(sample_mon.payload));
            if (result_mon.valid && result_mon.ready)
            begin
                got = result_mon.payload;
                if (expected_headings.size() == 0)
                begin
                    $display("%0t: result with nothing expected: %p", $realtime, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_headings.pop_front();
                    if (got.heading_tenths !== want.heading_tenths || got.sector !== want.sector
                        || got.center_x !== want.center_x || got.center_y !== want.center_y
                        || got.center_z !== want.center_z)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // Register writes take effect after any sample in the same cycle.
            if (cfg_we)
                case (cfg_index)
                    mvh_pkg::RegAxisMode:  mode_q  <= cfg_data[2:0];
                    mvh_pkg::RegOffsetX:   off_x   <= cfg_data;
                    mvh_pkg::RegOffsetY:   off_y   <= cfg_data;
                    mvh_pkg::RegOffsetZ:   off_z   <= cfg_data;
                    mvh_pkg::RegNorth:     north_q <= cfg_data[11:0];
                    mvh_pkg::RegAxisScale: scale_q <= cfg_data;
                    mvh_pkg::RegCalEnable: cal_on  <= cfg_data[0];
                    default: ;
                endcase
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Magnetometer vane heading testbench
// Drives directed and random magnetometer samples through a series of
// register settings under varying idle patterns and a long output stall,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int Steps      = 16;
    localparam int Latency    = Steps + 4;
    localparam int StallLimit = 20000;

    // An index past the register list; writes to it are ignored.
    localparam logic [2:0] RegUnknown = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          tx_idle;
    int          rx_idle;
    int          hold_requests;
    int          quiet_cycles;

    mvh_stream_if #(.payload_t(mvh_tb_types_pkg::mag_sample_t))     sample_ch ();
    mvh_stream_if #(.payload_t(mvh_tb_types_pkg::heading_result_t)) result_ch ();

    magnetometer_vane_heading_top #(
        .CORDIC_STEPS(Steps),
        .SAMPLE_BITS (16)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (sample_ch),
        .out_ch   (result_ch)
    );

    mvh_heading_checker #(.CORDIC_STEPS(Steps)) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_mon(sample_ch),
        .result_mon(result_ch),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int served;
        served = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (served != hold_requests)
            begin
                served = hold_requests;
                result_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            result_ch.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("magnetometer_vane_heading_top test failed");
            $finish;
        end
    end

    task automatic send_sample(input mvh_tb_types_pkg::mag_sample_t s);
        while ($urandom_range(99) < tx_idle)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.payload <= s;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (Latency + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly samples near the hard-iron offsets so headings sweep the circle.
    function automatic mvh_tb_types_pkg::mag_sample_t random_sample(input logic [15:0] ox,
                                                                    input logic [15:0] oy,
                                                                    input logic [15:0] oz);
        mvh_tb_types_pkg::mag_sample_t s;
        if ($urandom_range(3) == 0)
            s = 48'({$urandom, $urandom});
        else
        begin
            s.mag_x = ox + 16'($signed($urandom_range(4000)) - 2000);
            s.mag_y = oy + 16'($signed($urandom_range(4000)) - 2000);
            s.mag_z = oz + 16'($signed($urandom_range(4000)) - 2000);
        end
        return s;
    endfunction

    initial
    begin
        logic [15:0] ox, oy, oz, scale, north;
        mvh_tb_types_pkg::mag_sample_t s;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.payload = '0;
        tx_idle = 34;
        rx_idle = 87;
        hold_requests = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero vector, axis extremes, the four axis directions, empty centers.
        send_sample('0);
        send_sample({16'sh7fff, 16'sh7fff, 16'sh7fff});
        send_sample({16'sh8000, 16'sh8000, 16'sh8000});
        send_sample({16'sh8000, 16'sh7fff, 16'sh0000});
        send_sample({16'sh7fff, 16'sh8000, 16'sh0000});
        send_sample({16'sd100, 16'sd0, 16'sd0});
        send_sample({-16'sd100, 16'sd0, 16'sd0});
        send_sample({16'sd0, 16'sd100, 16'sd0});
        send_sample({16'sd0, -16'sd100, 16'sd0});
        send_sample({-16'sd100, -16'sd1, 16'sd5});
        wait_drained();

        // The settings walk the axis modes, including the two unused ones.
        for (int k = 0; k < 9; k++)
        begin
            ox = (k == 1) ? 16'h8000 : (k == 2) ? 16'h7fff : 16'($signed($urandom_range(600)) - 300);
            oy = (k == 1) ? 16'h7fff : (k == 2) ? 16'h8000 : 16'($signed($urandom_range(600)) - 300);
            oz = (k == 3) ? 16'h8000 : 16'($signed($urandom_range(600)) - 300);
            case (k)
                1: scale = 16'h8000;
                2: scale = 16'h7fff;
                3: scale = 16'h0000;
                4: scale = 16'hff00;
                default: scale = 16'($urandom_range(640) + 32);
            endcase
            north = (k == 2) ? 16'd3599 : (k == 5) ? 16'd4095 : (k == 6) ? 16'd3600
                    : 16'($urandom_range(3599));
            tx_idle = (k < 3) ? 34 : (k < 6) ? 87 : 0;
            rx_idle = (k < 3) ? 87 : (k < 6) ? 34 : 0;
            write_reg(mvh_pkg::RegAxisMode, {13'($urandom_range(8191)), 3'(k)});
            write_reg(mvh_pkg::RegOffsetX, ox);
            write_reg(mvh_pkg::RegOffsetY, oy);
            write_reg(mvh_pkg::RegOffsetZ, oz);
            write_reg(mvh_pkg::RegNorth, north);
            write_reg(mvh_pkg::RegAxisScale, scale);
            write_reg(mvh_pkg::RegCalEnable, 16'((k % 3) != 2));
            if (k == 4)
                write_reg(RegUnknown, 16'($urandom));
            cfg_we <= 1'b0;
            @(posedge clk);
            if (k == 1)
            begin
                // Samples exactly at the offsets give a zero vector.
                send_sample({ox, oy, oz});
                send_sample({pick_word(), pick_word(), pick_word()});
            end
            for (int n = 0; n < 75; n++)
            begin
                if (k == 7 && n == 10)
                    hold_requests = hold_requests + 1;
                s = random_sample(ox, oy, oz);
                send_sample(s);
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("magnetometer_vane_heading_top test passed");
        else
            $display("magnetometer_vane_heading_top test failed");
        $finish;
    end

endmodule
